// ===== rtl/can_id_census_table_defines.svh =====
// ============================================================================
// can_id_census_table_defines.svh
// Assertion macros used by the census table checker.
// ============================================================================
`ifndef CAN_ID_CENSUS_TABLE_DEFINES_SVH
`define CAN_ID_CENSUS_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CICT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CICT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cict_pkg.sv =====
// ============================================================================
// cict_pkg
// Types, marker identifiers and helper functions of the CAN identifier census.
// ============================================================================
package cict_pkg;

    localparam int ID_W     = 11;
    localparam int SLOT_W   = 6;
    localparam int FRAMES_W = 16;
    localparam int UNIQUE_W = 7;
    localparam int TOTAL_W  = 32;
    localparam int DROPS_W  = 16;
    localparam int HITS_W   = 2;

    // Identifiers seen only on the power-train bus
    localparam logic [ID_W-1:0] PT_MARK_A = 11'h0B5;
    localparam logic [ID_W-1:0] PT_MARK_B = 11'h0BA;
    localparam logic [ID_W-1:0] PT_MARK_C = 11'h198;
    // Identifiers seen only on the body bus
    localparam logic [ID_W-1:0] BODY_MARK_A = 11'h349;
    localparam logic [ID_W-1:0] BODY_MARK_B = 11'h2CA;
    localparam logic [ID_W-1:0] BODY_MARK_C = 11'h1D6;

    typedef enum logic [1:0] {
        MARK_NONE  = 2'd0,
        MARK_POWER = 2'd1,
        MARK_BODY  = 2'd2
    } marker_t;

    typedef enum logic [1:0] {
        VERDICT_SILENT       = 2'd0,
        VERDICT_POWER        = 2'd1,
        VERDICT_BODY         = 2'd2,
        VERDICT_INCONCLUSIVE = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [ID_W-1:0] can_id;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                is_new;
        logic                dropped;
        logic [FRAMES_W-1:0] id_frames;
        logic [UNIQUE_W-1:0] unique_ids;
        logic [TOTAL_W-1:0]  frames_seen;
        logic [DROPS_W-1:0]  ids_dropped;
        logic [HITS_W-1:0]   power_bus_hits;
        logic [HITS_W-1:0]   body_bus_hits;
        verdict_t            verdict;
    } out_word_t;

    function automatic marker_t marker_class(input logic [ID_W-1:0] id);
        marker_t cls;
        case (id) inside
            PT_MARK_A, PT_MARK_B, PT_MARK_C:       cls = MARK_POWER;
            BODY_MARK_A, BODY_MARK_B, BODY_MARK_C: cls = MARK_BODY;
            default:                               cls = MARK_NONE;
        endcase
        return cls;
    endfunction

    function automatic verdict_t bus_verdict(input logic              empty,
                                             input logic [HITS_W-1:0] power,
                                             input logic [HITS_W-1:0] body);
        verdict_t v;
        if (empty)
            v = VERDICT_SILENT;
        else if (power > body)
            v = VERDICT_POWER;
        else if (body > power)
            v = VERDICT_BODY;
        else
            v = VERDICT_INCONCLUSIVE;
        return v;
    endfunction

endpackage

// ===== rtl/cict_stream_if.sv =====
// ============================================================================
// cict_stream_if
// Valid/ready channel carrying one word of a type chosen per instance.
// ============================================================================
interface cict_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/can_id_census_table.sv =====
// ============================================================================
// can_id_census_table
// Census of distinct received CAN identifiers with per-identifier frame counts,
// drop count and a bus verdict from fixed marker identifiers.
// ============================================================================
//  channel  | dir | word         | fields
//  ---------+-----+--------------+------------------------------------------
//  frame    | in  | in_word_t    | can_id
//  result   | out | out_word_t   | slot, is_new, dropped, id_frames, ...
//
//  A new identifier is accepted, then searched for linearly, reading one
//  table entry per cycle from the single read port with registered read
//  data; the finished word then goes to the output register. A hit in
//  slot k ends the search early.
//  No clearing pass after reset: only entries below the fill count are read.
//  A finished word waits in the output register; the next frame is accepted
//  meanwhile, and its result waits in the done state until the register frees.
// ============================================================================
module can_id_census_table
    import cict_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    cict_stream_if.sink   frame,
    cict_stream_if.source result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    // table memories
    logic [ID_W-1:0]     id_mem  [TABLE_DEPTH];
    logic [FRAMES_W-1:0] frm_mem [TABLE_DEPTH];
    logic [ID_W-1:0]     rd_id_reg;
    logic [FRAMES_W-1:0] rd_frm_reg;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                pending_reg, pending_next;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [ID_W-1:0]     item_id_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [DROPS_W-1:0]  drop_reg, drop_next;
    logic [HITS_W-1:0]   power_reg, power_next;
    logic [HITS_W-1:0]   body_reg, body_next;
    out_word_t           res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_data_reg;

    logic                accept;
    logic                hit;
    logic                full;
    logic                search_end;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                do_insert;
    logic                do_drop;
    logic                load_out;
    logic                frm_wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [FRAMES_W-1:0] frm_wr_data;
    logic [FRAMES_W-1:0] frm_inc;
    logic [IDX_W-1:0]    fill_idx;
    marker_t             cls;

    assign frame.ready  = (state_reg == ST_IDLE);
    assign accept       = frame.valid && frame.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign fill_idx = fill_reg[IDX_W-1:0];
    assign full     = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign hit      = pending_reg && (rd_id_reg == item_id_reg);
    assign frm_inc  = rd_frm_reg + FRAMES_W'(1);
    assign cls      = marker_class(item_id_reg);

    always_comb
    begin
        rd_en      = (state_reg == ST_SEARCH) && !hit && (issue_idx_reg < fill_reg);
        search_end = (state_reg == ST_SEARCH) && (hit || (issue_idx_reg >= fill_reg));
        rd_addr    = issue_idx_reg[IDX_W-1:0];
        do_insert  = search_end && !hit && !full;
        do_drop    = search_end && !hit && full;
        load_out   = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

        frm_wr_en   = (search_end && hit) || do_insert;
        wr_addr     = hit ? cmp_idx_reg : fill_idx;
        frm_wr_data = hit ? frm_inc : FRAMES_W'(1);
    end

    // counters and result word
    always_comb
    begin
        fill_next  = fill_reg;
        total_next = total_reg;
        drop_next  = drop_reg;
        power_next = power_reg;
        body_next  = body_reg;
        if (search_end)
        begin
            total_next = total_reg + TOTAL_W'(1);
        end
        if (do_drop)
        begin
            drop_next = drop_reg + DROPS_W'(1);
        end
        if (do_insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
            case (cls)
                MARK_POWER: power_next = power_reg + HITS_W'(1);
                MARK_BODY:  body_next  = body_reg + HITS_W'(1);
                default:    ;
            endcase
        end

        res_next.slot           = hit ? SLOT_W'(cmp_idx_reg)
                                      : (do_insert ? SLOT_W'(fill_idx) : '0);
        res_next.is_new         = do_insert;
        res_next.dropped        = do_drop;
        res_next.id_frames      = hit ? frm_inc
                                      : (do_insert ? FRAMES_W'(1) : '0);
        res_next.unique_ids     = UNIQUE_W'(fill_next);
        res_next.frames_seen    = total_next;
        res_next.ids_dropped    = drop_next;
        res_next.power_bus_hits = power_next;
        res_next.body_bus_hits  = body_next;
        res_next.verdict        = bus_verdict(fill_next == '0, power_next, body_next);
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        pending_next   = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_idx_next = '0;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                pending_next = rd_en;
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (search_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_idx_reg <= '0;
            pending_reg   <= 1'b0;
            fill_reg      <= '0;
            total_reg     <= '0;
            drop_reg      <= '0;
            power_reg     <= '0;
            body_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
            pending_reg   <= pending_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            drop_reg      <= drop_next;
            power_reg     <= power_next;
            body_reg      <= body_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_id_reg <= frame.data.can_id;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_addr;
        end
        if (search_end)
        begin
            res_reg <= res_next;
        end
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    // table memories: one read port, one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_frm_reg <= frm_mem[rd_addr];
        end
        if (do_insert)
        begin
            id_mem[wr_addr] <= item_id_reg;
        end
        if (frm_wr_en)
        begin
            frm_mem[wr_addr] <= frm_wr_data;
        end
    end

endmodule

// ===== rtl/cict_checker.sv =====
// ============================================================================
// cict_checker
// Port-level checks on the result channel of the census table.
// ============================================================================
`include "can_id_census_table_defines.svh"

module cict_checker
    import cict_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_ready,
    input out_word_t result_data
);

    `CICT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "result word changed while stalled")
    `CICT_ASSERT_NOW(a_drop_fields, result_valid && result_data.dropped, (result_data.slot == '0) && (result_data.id_frames == '0) && !result_data.is_new, "dropped word carries slot or count")
    `CICT_ASSERT_NOW(a_new_count, result_valid && result_data.is_new, result_data.id_frames == FRAMES_W'(1), "inserted identifier count is not one")
    `CICT_ASSERT_NOW(a_silent_empty, result_valid, ((result_data.verdict == VERDICT_SILENT) == (result_data.unique_ids == '0)) || (result_data.unique_ids == '0), "silent verdict does not match empty table")

endmodule

bind can_id_census_table cict_checker u_cict_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

// ===== tb/tb_can_id_census_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_can_id_census_table
// Self-checking bench for the CAN identifier census table. A short table of
// directed frames covers the first inserts, repeated hits and every marker.
// Random traffic then fills the table and forces drops.
// Result words are checked field by field against typed rows or the census model.
// ============================================================================
module tb_can_id_census_table;
    import cict_pkg::*;

    localparam int CENSUS_DEPTH = 64;
    localparam int RANDOM_FRAMES = 834;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_CYCLES = 4_000_000;

    typedef struct {
        logic [ID_W-1:0] can_id;
        int              reps;
        bit              typed;
        out_word_t       want;
    } census_row_t;

    logic clk;
    logic rst_n;

    cict_stream_if #(.word_t(in_word_t))  frame_ch ();
    cict_stream_if #(.word_t(out_word_t)) result_ch ();

    can_id_census_table #(
        .TABLE_DEPTH(CENSUS_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .frame(frame_ch),
        .result(result_ch)
    );

    // census model state
    logic [ID_W-1:0]     census_ids [CENSUS_DEPTH];
    logic [FRAMES_W-1:0] census_counts [CENSUS_DEPTH];
    int                  census_fill;
    logic [TOTAL_W-1:0]  census_total;
    logic [DROPS_W-1:0]  census_drops;
    logic [HITS_W-1:0]   census_power;
    logic [HITS_W-1:0]   census_body;

    out_word_t awaited_tally [$];
    int        mismatches;
    int        words_out;
    int        cycle_cnt;
    bit        hold_req;
    bit        calm;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic out_word_t census_record(input logic [ID_W-1:0] id);
        out_word_t w;
        int        hit_at;
        hit_at = -1;
        for (int i = 0; i < census_fill; i++)
        begin
            if (census_ids[i] == id)
            begin
                hit_at = i;
                break;
            end
        end
        w = '0;
        census_total = census_total + 1'b1;
        if (hit_at >= 0)
        begin
            census_counts[hit_at] = census_counts[hit_at] + 1'b1;
            w.slot = SLOT_W'(hit_at);
            w.id_frames = census_counts[hit_at];
        end
        else if (census_fill >= CENSUS_DEPTH)
        begin
            census_drops = census_drops + 1'b1;
            w.dropped = 1'b1;
        end
        else
        begin
            w.slot = SLOT_W'(census_fill);
            census_ids[census_fill] = id;
            census_counts[census_fill] = FRAMES_W'(1);
            w.id_frames = FRAMES_W'(1);
            w.is_new = 1'b1;
            census_fill++;
            if (id == PT_MARK_A || id == PT_MARK_B || id == PT_MARK_C)
                census_power = census_power + 1'b1;
            else if (id == BODY_MARK_A || id == BODY_MARK_B || id == BODY_MARK_C)
                census_body = census_body + 1'b1;
        end
        w.unique_ids = UNIQUE_W'(census_fill);
        w.frames_seen = census_total;
        w.ids_dropped = census_drops;
        w.power_bus_hits = census_power;
        w.body_bus_hits = census_body;
        if (census_fill == 0)
            w.verdict = VERDICT_SILENT;
        else if (census_power > census_body)
            w.verdict = VERDICT_POWER;
        else if (census_body > census_power)
            w.verdict = VERDICT_BODY;
        else
            w.verdict = VERDICT_INCONCLUSIVE;
        return w;
    endfunction

    // expected word of an insert or hit, no drops so far
    function automatic out_word_t tally(input int slot, input bit fresh, input int frames,
                                        input int uniq, input int seen, input int pw,
                                        input int bd, input verdict_t v);
        out_word_t w;
        w = '0;
        w.slot = SLOT_W'(slot);
        w.is_new = fresh;
        w.id_frames = FRAMES_W'(frames);
        w.unique_ids = UNIQUE_W'(uniq);
        w.frames_seen = TOTAL_W'(seen);
        w.power_bus_hits = HITS_W'(pw);
        w.body_bus_hits = HITS_W'(bd);
        w.verdict = v;
        return w;
    endfunction

    function automatic logic [ID_W-1:0] pick_census_id();
        int r;
        logic [ID_W-1:0] id;
        r = $urandom_range(99);
        if (r < 45 && census_fill > 0)
            id = census_ids[$urandom_range(census_fill - 1)];
        else if (r < 55)
        begin
            case ($urandom_range(5))
                0: id = PT_MARK_A;
                1: id = PT_MARK_B;
                2: id = PT_MARK_C;
                3: id = BODY_MARK_A;
                4: id = BODY_MARK_B;
                default: id = BODY_MARK_C;
            endcase
        end
        else if (r < 62)
            id = $urandom_range(1) ? '1 : '0;
        else
            id = ID_W'($urandom_range(2047));
        return id;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("[%0t] word %0d: %s", $realtime, words_out, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic offer_frame(input logic [ID_W-1:0] id, input bit typed,
                               input out_word_t want);
        out_word_t predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 22)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.data <= in_word_t'(id);
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        predicted = census_record(id);
        awaited_tally.push_back(typed ? want : predicted);
    endtask

    // result side: random backpressure, plus one long hold on request
    initial
    begin : result_sink
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            result_ch.ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin : result_check
        out_word_t got;
        out_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (awaited_tally.size() == 0)
                flag_mismatch("result word with nothing expected");
            else
            begin
                want = awaited_tally.pop_front();
                check_field("slot", 32'(got.slot), 32'(want.slot));
                check_field("is_new", 32'(got.is_new), 32'(want.is_new));
                check_field("dropped", 32'(got.dropped), 32'(want.dropped));
                check_field("id_frames", 32'(got.id_frames), 32'(want.id_frames));
                check_field("unique_ids", 32'(got.unique_ids), 32'(want.unique_ids));
                check_field("frames_seen", got.frames_seen, want.frames_seen);
                check_field("ids_dropped", 32'(got.ids_dropped), 32'(want.ids_dropped));
                check_field("power_bus_hits", 32'(got.power_bus_hits),
                            32'(want.power_bus_hits));
                check_field("body_bus_hits", 32'(got.body_bus_hits),
                            32'(want.body_bus_hits));
                check_field("verdict", 32'(got.verdict), 32'(want.verdict));
            end
            words_out++;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("tb_can_id_census_table: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        census_row_t rows [$];
        int          n;
        rst_n = 1'b0;
        frame_ch.valid = 1'b0;
        frame_ch.data = '0;
        hold_req = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        words_out = 0;
        cycle_cnt = 0;
        census_fill = 0;
        census_total = '0;
        census_drops = '0;
        census_power = '0;
        census_body = '0;

        rows.push_back('{11'h000, 1, 1'b1, tally(0, 1, 1, 1, 1, 0, 0, VERDICT_INCONCLUSIVE)});
        rows.push_back('{11'h7FF, 1, 1'b1, tally(1, 1, 1, 2, 2, 0, 0, VERDICT_INCONCLUSIVE)});
        rows.push_back('{11'h000, 1, 1'b1, tally(0, 0, 2, 2, 3, 0, 0, VERDICT_INCONCLUSIVE)});
        rows.push_back('{PT_MARK_A, 1, 1'b1, tally(2, 1, 1, 3, 4, 1, 0, VERDICT_POWER)});
        rows.push_back('{BODY_MARK_A, 1, 1'b1,
                         tally(3, 1, 1, 4, 5, 1, 1, VERDICT_INCONCLUSIVE)});
        rows.push_back('{BODY_MARK_C, 1, 1'b1, tally(4, 1, 1, 5, 6, 1, 2, VERDICT_BODY)});
        rows.push_back('{PT_MARK_B, 1, 1'b0, '0});
        rows.push_back('{PT_MARK_C, 1, 1'b0, '0});
        rows.push_back('{BODY_MARK_B, 1, 1'b0, '0});
        rows.push_back('{PT_MARK_A, 1, 1'b0, '0});
        rows.push_back('{11'h555, 1, 1'b0, '0});
        rows.push_back('{11'h2AA, 1, 1'b0, '0});
        rows.push_back('{11'h7FF, 1, 1'b0, '0});
        rows.push_back('{11'h001, 1, 1'b0, '0});
        rows.push_back('{11'h400, 1, 1'b0, '0});
        rows.push_back('{BODY_MARK_B, 1, 1'b0, '0});

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[r])
            for (int k = 0; k < rows[r].reps; k++)
                offer_frame(rows[r].can_id, rows[r].typed, rows[r].want);

        // sender pause: let every outstanding word drain
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (awaited_tally.size() != 0)
            @(posedge clk);

        // random traffic: hits, markers, new ids; table fills, then drops
        for (n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n == 200)
                hold_req = 1'b1;
            calm = (n >= 400 && n < 550);
            offer_frame(pick_census_id(), 1'b0, '0);
        end
        calm = 1'b0;
        @(negedge clk);
        frame_ch.valid <= 1'b0;

        while (awaited_tally.size() != 0)
            @(posedge clk);
        repeat (CENSUS_DEPTH + 16) @(posedge clk);

        if (mismatches == 0)
            $display("tb_can_id_census_table: PASS");
        else
            $display("tb_can_id_census_table: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cict_pkg.sv
rtl/cict_stream_if.sv
rtl/can_id_census_table.sv
rtl/cict_checker.sv
tb/tb_can_id_census_table.sv
